[sv/bffa_pkg.sv]
// Shared types and constants for the banked framebuffer flush addresser.
package bffa_pkg;

    // Input item field widths.
    localparam int unsigned COORD_W = 14;

    // Result field widths.
    localparam int unsigned SRC_W   = 26;
    localparam int unsigned BANK_W  = 14;
    localparam int unsigned DEST_W  = 20;
    localparam int unsigned LEN_W   = 13;

    // Configuration register widths.
    localparam int unsigned DIM_W    = 13;
    localparam int unsigned STRIDE_W = 15;
    localparam int unsigned SHIFT_W  = 5;

    // Configuration port widths.
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 15;

    // Item function codes.
    typedef enum logic {
        FUNC_START = 1'b0,
        FUNC_ROW   = 1'b1
    } func_t;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_FLUSH_ENABLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_LINE_STRIDE   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_APERTURE_SHIFT = 3'd4;

    // Reset values of the configuration registers.
    localparam logic                RST_FLUSH_ENABLE = 1'b1;
    localparam logic [DIM_W-1:0]    RST_SCREEN_WIDTH = 13'd640;
    localparam logic [DIM_W-1:0]    RST_SCREEN_HEIGHT = 13'd480;
    localparam logic [STRIDE_W-1:0] RST_LINE_STRIDE  = 15'd640;
    localparam logic [SHIFT_W-1:0]  RST_APERTURE_SHIFT = 5'd16;

    // Legal range of the aperture shift.
    localparam logic [SHIFT_W-1:0] SHIFT_MIN = 5'd12;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX = 5'd20;

endpackage

[sv/banked_framebuffer_flush_addresser_unit.sv]
// Top level of the banked framebuffer flush addresser.
//
// Usage: a start transaction (func = start) on the input channel clips the
// rectangle min_x..max_x, min_y..max_y (max exclusive) to the screen and arms
// the row sequencer; it produces no result. Each following row transaction
// (func = row) produces one copy descriptor on the output channel: shadow
// offset, bank, aperture offset, first part length, and a bank step with the
// remaining length that goes to offset 0 of the next bank. A row transaction
// while no rectangle is armed produces nothing. A start while a rectangle is
// still running replaces it. An empty rectangle or a disabled flush arms
// nothing.
// Timing: an input transaction is registered in the input register, then
// worked into the result register, from which its descriptor is offered.
// One transaction is accepted every cycle while the receiver does not stall;
// the rate is set by the single compute stage, which updates the row state
// as it writes the result register.
// The configuration port is always ready and writes one register per
// transaction. Reset clears all control state and loads the register defaults.
// When the receiver stalls, the result register holds, and the input channel
// stalls once the input register also holds a transaction.
module banked_framebuffer_flush_addresser_unit #(
    parameter int unsigned MAX_DIM = 4096
) (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [bffa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [bffa_pkg::CFG_DATA_W-1:0]     cfg_data,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                func,
    input  logic signed [bffa_pkg::COORD_W-1:0] min_x,
    input  logic signed [bffa_pkg::COORD_W-1:0] min_y,
    input  logic signed [bffa_pkg::COORD_W-1:0] max_x,
    input  logic signed [bffa_pkg::COORD_W-1:0] max_y,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bffa_pkg::SRC_W-1:0]          src_offset,
    output logic [bffa_pkg::BANK_W-1:0]         bank,
    output logic [bffa_pkg::DEST_W-1:0]         dest_offset,
    output logic [bffa_pkg::LEN_W-1:0]          first_len,
    output logic                                bank_step,
    output logic [bffa_pkg::LEN_W-1:0]          second_len,
    output logic                                last_row
);
    import bffa_pkg::*;

    // Screen limit after the clamp to MAX_DIM, one bit wider than a register.
    localparam int unsigned CLIP_W = DIM_W + 1;
    localparam logic [CLIP_W-1:0] MAX_DIM_C = CLIP_W'(MAX_DIM);
    localparam int unsigned PROD_W = DIM_W + STRIDE_W;
    localparam int unsigned AP_W = DEST_W + 1;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic                flush_enable_reg;
    logic [DIM_W-1:0]    screen_width_reg;
    logic [DIM_W-1:0]    screen_height_reg;
    logic [STRIDE_W-1:0] line_stride_reg;
    logic [SHIFT_W-1:0]  aperture_shift_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flush_enable_reg   <= RST_FLUSH_ENABLE;
            screen_width_reg   <= RST_SCREEN_WIDTH;
            screen_height_reg  <= RST_SCREEN_HEIGHT;
            line_stride_reg    <= RST_LINE_STRIDE;
            aperture_shift_reg <= RST_APERTURE_SHIFT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            // Writes to indexes past the register list are dropped.
            unique case (cfg_index)
                REG_FLUSH_ENABLE:   flush_enable_reg   <= cfg_data[0];
                REG_SCREEN_WIDTH:   screen_width_reg   <= cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:  screen_height_reg  <= cfg_data[DIM_W-1:0];
                REG_LINE_STRIDE:    line_stride_reg    <= cfg_data[STRIDE_W-1:0];
                REG_APERTURE_SHIFT: aperture_shift_reg <= cfg_data[SHIFT_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input register feeding the result register
    // ------------------------------------------------------------------
    logic                      s1_valid_reg;
    logic                      s1_valid_next;
    func_t                     s1_func_reg;
    logic signed [COORD_W-1:0] s1_min_x_reg;
    logic signed [COORD_W-1:0] s1_min_y_reg;
    logic signed [COORD_W-1:0] s1_max_x_reg;
    logic signed [COORD_W-1:0] s1_max_y_reg;

    logic out_valid_reg;
    logic out_valid_next;
    logic out_free;
    logic in_take;
    logic advance;

    // The result register can take new data when it is empty or being read.
    assign out_free = !out_valid_reg || !out_stall;
    assign advance  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_take  = in_valid && !in_stall;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_take)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_func_reg  <= func_t'(func);
            s1_min_x_reg <= min_x;
            s1_min_y_reg <= min_y;
            s1_max_x_reg <= max_x;
            s1_max_y_reg <= max_y;
        end
    end

    // ------------------------------------------------------------------
    // Row sequencer state
    // ------------------------------------------------------------------
    logic              busy_reg;
    logic              busy_next;
    logic [LEN_W-1:0]  row_left_reg;
    logic [LEN_W-1:0]  row_left_next;
    logic [SRC_W-1:0]  cur_src_reg;
    logic [SRC_W-1:0]  cur_src_next;
    logic [LEN_W-1:0]  row_len_reg;
    logic [LEN_W-1:0]  row_len_next;

    // ------------------------------------------------------------------
    // Start: clip the rectangle and find the shadow offset of its first row
    // ------------------------------------------------------------------
    logic [CLIP_W-1:0]        w_clip;
    logic [CLIP_W-1:0]        h_clip;
    logic signed [CLIP_W:0]   w_s;
    logic signed [CLIP_W:0]   h_s;
    logic signed [CLIP_W:0]   x0_c;
    logic signed [CLIP_W:0]   y0_c;
    logic signed [CLIP_W:0]   x1_c;
    logic signed [CLIP_W:0]   y1_c;
    logic signed [CLIP_W+1:0] x_span;
    logic signed [CLIP_W+1:0] y_span;
    logic                     start_ok;
    logic [PROD_W-1:0]        row_prod;
    logic [SRC_W-1:0]         start_src;

    always_comb
    begin
        w_clip = (CLIP_W'(screen_width_reg) > MAX_DIM_C) ? MAX_DIM_C
                                                          : CLIP_W'(screen_width_reg);
        h_clip = (CLIP_W'(screen_height_reg) > MAX_DIM_C) ? MAX_DIM_C
                                                           : CLIP_W'(screen_height_reg);
        w_s = signed'({1'b0, w_clip});
        h_s = signed'({1'b0, h_clip});

        // Negative left and top edges clamp to zero, far edges to the screen.
        x0_c = s1_min_x_reg[COORD_W-1] ? '0 : (CLIP_W+1)'(s1_min_x_reg);
        y0_c = s1_min_y_reg[COORD_W-1] ? '0 : (CLIP_W+1)'(s1_min_y_reg);
        x1_c = ((CLIP_W+1)'(s1_max_x_reg) > w_s) ? w_s : (CLIP_W+1)'(s1_max_x_reg);
        y1_c = ((CLIP_W+1)'(s1_max_y_reg) > h_s) ? h_s : (CLIP_W+1)'(s1_max_y_reg);

        x_span = (CLIP_W+2)'(x1_c) - (CLIP_W+2)'(x0_c);
        y_span = (CLIP_W+2)'(y1_c) - (CLIP_W+2)'(y0_c);
        start_ok = flush_enable_reg && (x_span > 0) && (y_span > 0);

        // With a non-empty rectangle the clipped origin is below the screen
        // limit, so its low bits carry the whole value.
        row_prod  = PROD_W'(y0_c[DIM_W-1:0]) * PROD_W'(line_stride_reg);
        start_src = row_prod[SRC_W-1:0] + SRC_W'(x0_c[DIM_W-1:0]);
    end

    // ------------------------------------------------------------------
    // Row: locate the row start in the aperture and split at the bank end
    // ------------------------------------------------------------------
    logic [SHIFT_W-1:0] eff_shift;
    logic [AP_W-1:0]    ap_size;
    logic [AP_W-1:0]    ap_mask;
    logic [DEST_W-1:0]  row_dest;
    logic [BANK_W-1:0]  row_bank;
    logic [AP_W-1:0]    next_reach;
    logic [AP_W-1:0]    room;
    logic               row_step;
    logic               row_split;
    logic [LEN_W-1:0]   row_first;
    logic [LEN_W-1:0]   row_second;

    always_comb
    begin
        priority if (aperture_shift_reg < SHIFT_MIN)
        begin
            eff_shift = SHIFT_MIN;
        end
        else if (aperture_shift_reg > SHIFT_MAX)
        begin
            eff_shift = SHIFT_MAX;
        end
        else
        begin
            eff_shift = aperture_shift_reg;
        end

        ap_size  = AP_W'(1) << eff_shift;
        ap_mask  = ap_size - AP_W'(1);
        row_dest = cur_src_reg[DEST_W-1:0] & ap_mask[DEST_W-1:0];
        row_bank = BANK_W'(cur_src_reg >> eff_shift);

        // The bank steps whenever the next row start reaches the bank end,
        // even when this row itself fits.
        next_reach = AP_W'(row_dest) + AP_W'(line_stride_reg);
        row_step   = next_reach >= ap_size;
        room       = ap_size - AP_W'(row_dest);
        row_split  = row_step && (room <= AP_W'(row_len_reg));

        if (row_split)
        begin
            row_first  = room[LEN_W-1:0];
            row_second = row_len_reg - room[LEN_W-1:0];
        end
        else
        begin
            row_first  = row_len_reg;
            row_second = '0;
        end
    end

    // ------------------------------------------------------------------
    // State update
    // ------------------------------------------------------------------
    logic row_emit;

    assign row_emit = advance && (s1_func_reg == FUNC_ROW) && busy_reg;

    always_comb
    begin
        busy_next     = busy_reg;
        row_left_next = row_left_reg;
        cur_src_next  = cur_src_reg;
        row_len_next  = row_len_reg;
        if (advance && (s1_func_reg == FUNC_START))
        begin
            // A start always drops whatever rectangle was running.
            busy_next = start_ok;
            if (start_ok)
            begin
                cur_src_next  = start_src;
                row_len_next  = x_span[LEN_W-1:0];
                row_left_next = y_span[LEN_W-1:0];
            end
        end
        else if (row_emit)
        begin
            cur_src_next  = cur_src_reg + SRC_W'(line_stride_reg);
            row_left_next = row_left_reg - LEN_W'(1);
            busy_next     = (row_left_reg != LEN_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b0;
            row_left_reg <= '0;
            cur_src_reg  <= '0;
            row_len_reg  <= '0;
        end
        else
        begin
            busy_reg     <= busy_next;
            row_left_reg <= row_left_next;
            cur_src_reg  <= cur_src_next;
            row_len_reg  <= row_len_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic [SRC_W-1:0]  src_offset_reg;
    logic [BANK_W-1:0] bank_reg;
    logic [DEST_W-1:0] dest_offset_reg;
    logic [LEN_W-1:0]  first_len_reg;
    logic              bank_step_reg;
    logic [LEN_W-1:0]  second_len_reg;
    logic              last_row_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_free)
        begin
            out_valid_next = row_emit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (row_emit)
        begin
            src_offset_reg  <= cur_src_reg;
            bank_reg        <= row_bank;
            dest_offset_reg <= row_dest;
            first_len_reg   <= row_first;
            bank_step_reg   <= row_step;
            second_len_reg  <= row_second;
            last_row_reg    <= (row_left_reg == LEN_W'(1));
        end
    end

    assign out_valid   = out_valid_reg;
    assign src_offset  = src_offset_reg;
    assign bank        = bank_reg;
    assign dest_offset = dest_offset_reg;
    assign first_len   = first_len_reg;
    assign bank_step   = bank_step_reg;
    assign second_len  = second_len_reg;
    assign last_row    = last_row_reg;

endmodule

[sv/bffa_checker.sv]
// Port-level assertions for the flush addresser and their bind to the top level.
module bffa_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [bffa_pkg::SRC_W-1:0]  src_offset,
    input logic [bffa_pkg::LEN_W-1:0]  first_len,
    input logic                        bank_step,
    input logic [bffa_pkg::LEN_W-1:0]  second_len
);
    import bffa_pkg::*;

    // A stalled result stays offered.
    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // A stalled result keeps its shadow offset and both lengths.
    a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(src_offset) && $stable(first_len)
                                   && $stable(second_len))
        else $error("result payload changed while stalled");

    // Every row has at least one byte before the bank end.
    a_first_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> first_len != LEN_W'(0))
        else $error("descriptor with empty first part");

    // A second part only exists after a bank step.
    a_second_needs_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !bank_step |-> second_len == LEN_W'(0))
        else $error("second part without a bank step");

endmodule

bind banked_framebuffer_flush_addresser_unit bffa_checker u_bffa_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .src_offset (src_offset),
    .first_len  (first_len),
    .bank_step  (bank_step),
    .second_len (second_len)
);

[test/banked_framebuffer_flush_addresser_unit_test.sv]
// Self-checking testbench for the banked framebuffer flush addresser unit.
`timescale 1ns / 100ps

module banked_framebuffer_flush_addresser_unit_test;

    import bffa_pkg::*;

    // Clip limit for the screen size; the block is built with the same value.
    localparam int unsigned DIM_LIMIT = 4096;

    // Shadow offsets live in a 26-bit space and wrap around.
    localparam longint unsigned SRC_SPACE = 64'd1 << SRC_W;

    // One input transaction as the sender presents it.
    typedef struct {
        func_t                      func;
        logic signed [COORD_W-1:0]  min_x;
        logic signed [COORD_W-1:0]  min_y;
        logic signed [COORD_W-1:0]  max_x;
        logic signed [COORD_W-1:0]  max_y;
    } flush_item_t;

    // One row copy descriptor as the block should deliver it.
    typedef struct {
        logic [SRC_W-1:0]   src_offset;
        logic [BANK_W-1:0]  bank;
        logic [DEST_W-1:0]  dest_offset;
        logic [LEN_W-1:0]   first_len;
        logic               bank_step;
        logic [LEN_W-1:0]   second_len;
        logic               last_row;
    } row_desc_t;

    // Clock and reset. Reset is held only at the start of the run.
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    always
    begin
        #6;
        clk = 1'b1;
        #6;
        clk = 1'b0;
    end

    // Block ports. Every input starts at a known value.
    logic                       cfg_valid = 1'b0;
    logic                       cfg_ready;
    logic [CFG_IDX_W-1:0]       cfg_index = '0;
    logic [CFG_DATA_W-1:0]      cfg_data = '0;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic                       func = 1'b0;
    logic signed [COORD_W-1:0]  min_x = '0;
    logic signed [COORD_W-1:0]  min_y = '0;
    logic signed [COORD_W-1:0]  max_x = '0;
    logic signed [COORD_W-1:0]  max_y = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [SRC_W-1:0]           src_offset;
    logic [BANK_W-1:0]          bank;
    logic [DEST_W-1:0]          dest_offset;
    logic [LEN_W-1:0]           first_len;
    logic                       bank_step;
    logic [LEN_W-1:0]           second_len;
    logic                       last_row;

    banked_framebuffer_flush_addresser_unit #(
        .MAX_DIM     (DIM_LIMIT)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .func        (func),
        .min_x       (min_x),
        .min_y       (min_y),
        .max_x       (max_x),
        .max_y       (max_y),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .src_offset  (src_offset),
        .bank        (bank),
        .dest_offset (dest_offset),
        .first_len   (first_len),
        .bank_step   (bank_step),
        .second_len  (second_len),
        .last_row    (last_row)
    );

    // Items waiting to be offered, and the descriptors the block still owes us.
    flush_item_t pending_items[$];
    row_desc_t   expected_descs[$];
    flush_item_t driven_item;

    int items_queued = 0;
    int items_accepted = 0;
    int error_count = 0;

    // Idling knobs: an odds value of N gives a one-in-N chance that a burst
    // starts; zero turns idling off on that side.
    int gap_odds = 0;
    int stall_odds = 0;
    int send_gap = 0;
    int stall_left = 0;
    bit long_hold_go = 1'b0;
    bit long_hold_taken = 1'b0;
    int hold_left = 0;

    // Our copy of the configuration registers, as last written.
    logic                   mdl_enable;
    logic [DIM_W-1:0]       mdl_width;
    logic [DIM_W-1:0]       mdl_height;
    logic [STRIDE_W-1:0]    mdl_stride;
    logic [SHIFT_W-1:0]     mdl_shift;

    // Our copy of the row sequencer: whether a rectangle is armed, rows still
    // to go, the shadow offset of the next row and the bytes in each row.
    bit                     rect_armed;
    logic [LEN_W-1:0]       rows_left;
    logic [SRC_W-1:0]       next_src;
    logic [LEN_W-1:0]       row_bytes;

    // Every mismatch goes through here: one line and one count.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        error_count++;
    endtask

    // Works out what one accepted item does to the row sequencer and queues
    // the descriptor that a row item produces.
    task automatic predict_row_desc(input flush_item_t it);
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int unsigned sh;
        longint unsigned apsize;
        longint unsigned dest;
        longint unsigned room;
        longint unsigned off;
        row_desc_t d;
        if (it.func == FUNC_START) begin
            w = (int'(mdl_width) > int'(DIM_LIMIT)) ? int'(DIM_LIMIT) : int'(mdl_width);
            h = (int'(mdl_height) > int'(DIM_LIMIT)) ? int'(DIM_LIMIT) : int'(mdl_height);
            x0 = int'(it.min_x);
            y0 = int'(it.min_y);
            x1 = int'(it.max_x);
            y1 = int'(it.max_y);
            // A new start always drops whatever rectangle was running.
            rect_armed = 1'b0;
            if (x0 < 0) x0 = 0;
            if (y0 < 0) y0 = 0;
            if (x1 > w) x1 = w;
            if (y1 > h) y1 = h;
            if (!mdl_enable || x1 - x0 < 1 || y1 - y0 < 1)
                return;
            off = 64'(y0) * 64'(mdl_stride) + 64'(x0);
            next_src = SRC_W'(off % SRC_SPACE);
            row_bytes = LEN_W'(x1 - x0);
            rows_left = LEN_W'(y1 - y0);
            rect_armed = 1'b1;
        end
        else if (rect_armed) begin
            sh = 32'(mdl_shift);
            if (sh < 32'(SHIFT_MIN)) sh = 32'(SHIFT_MIN);
            if (sh > 32'(SHIFT_MAX)) sh = 32'(SHIFT_MAX);
            apsize = 64'd1 << sh;
            dest = 64'(next_src) & (apsize - 64'd1);
            d.src_offset = next_src;
            d.bank = BANK_W'(next_src >> sh);
            d.dest_offset = DEST_W'(dest);
            d.first_len = row_bytes;
            d.bank_step = 1'b0;
            d.second_len = '0;
            // The bank steps when the next row would start at or past the
            // bank end; the row splits only if it actually reaches that end.
            if (dest + 64'(mdl_stride) >= apsize) begin
                room = apsize - dest;
                d.bank_step = 1'b1;
                if (room <= 64'(row_bytes)) begin
                    d.first_len = LEN_W'(room);
                    d.second_len = LEN_W'(64'(row_bytes) - room);
                end
            end
            d.last_row = (rows_left == LEN_W'(1));
            expected_descs.push_back(d);
            next_src = SRC_W'((64'(next_src) + 64'(mdl_stride)) % SRC_SPACE);
            rows_left = rows_left - LEN_W'(1);
            if (rows_left == '0)
                rect_armed = 1'b0;
        end
    endtask

    // Configuration side: track every register write the block accepts.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mdl_enable = RST_FLUSH_ENABLE;
            mdl_width = RST_SCREEN_WIDTH;
            mdl_height = RST_SCREEN_HEIGHT;
            mdl_stride = RST_LINE_STRIDE;
            mdl_shift = RST_APERTURE_SHIFT;
        end
        else if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_FLUSH_ENABLE:   mdl_enable = cfg_data[0];
                REG_SCREEN_WIDTH:   mdl_width = cfg_data[DIM_W-1:0];
                REG_SCREEN_HEIGHT:  mdl_height = cfg_data[DIM_W-1:0];
                REG_LINE_STRIDE:    mdl_stride = cfg_data[STRIDE_W-1:0];
                REG_APERTURE_SHIFT: mdl_shift = cfg_data[SHIFT_W-1:0];
                default:            ;
            endcase
        end
    end

    // Driver. A transaction completes when valid is high and stall is low at
    // the edge; only then, or while nothing is offered, is the next item taken
    // from the pending queue, so a stalled payload never changes. After an item,
    // the sender may go quiet for a random burst of cycles.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            rect_armed = 1'b0;
            rows_left = '0;
            next_src = '0;
            row_bytes = '0;
            send_gap = 0;
        end
        else begin
            if (in_valid && !in_stall) begin
                predict_row_desc(driven_item);
                items_accepted++;
            end
            if (!in_valid || !in_stall) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (pending_items.size() != 0) begin
                    driven_item = pending_items.pop_front();
                    func <= driven_item.func;
                    min_x <= driven_item.min_x;
                    min_y <= driven_item.min_y;
                    max_x <= driven_item.max_x;
                    max_y <= driven_item.max_y;
                    in_valid <= 1'b1;
                    if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
                        send_gap = $urandom_range(1, 11);
                end
                else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor. Each descriptor taken from the block is compared field by
    // field with the oldest one we expect. The receiver stalls in random
    // bursts, and once holds off for a long stretch so the block backs up.
    always @(posedge clk or negedge rst_n)
    begin
        row_desc_t want;
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_left = 0;
            hold_left = 0;
        end
        else begin
            if (out_valid && !out_stall) begin
                if (expected_descs.size() == 0) begin
                    report_mismatch("descriptor delivered while none was expected");
                end
                else begin
                    want = expected_descs.pop_front();
                    if (src_offset !== want.src_offset)
                        report_mismatch($sformatf("src_offset %0h, expected %0h",
                            src_offset, want.src_offset));
                    if (bank !== want.bank)
                        report_mismatch($sformatf("bank %0h, expected %0h",
                            bank, want.bank));
                    if (dest_offset !== want.dest_offset)
                        report_mismatch($sformatf("dest_offset %0h, expected %0h",
                            dest_offset, want.dest_offset));
                    if (first_len !== want.first_len)
                        report_mismatch($sformatf("first_len %0d, expected %0d",
                            first_len, want.first_len));
                    if (bank_step !== want.bank_step)
                        report_mismatch($sformatf("bank_step %0b, expected %0b",
                            bank_step, want.bank_step));
                    if (second_len !== want.second_len)
                        report_mismatch($sformatf("second_len %0d, expected %0d",
                            second_len, want.second_len));
                    if (last_row !== want.last_row)
                        report_mismatch($sformatf("last_row %0b, expected %0b",
                            last_row, want.last_row));
                end
            end
            if (long_hold_go && !long_hold_taken) begin
                long_hold_taken = 1'b1;
                hold_left = 150;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1) begin
                stall_left = $urandom_range(0, 10);
                out_stall <= 1'b1;
            end
            else begin
                out_stall <= 1'b0;
            end
        end
    end

    // One configuration transaction. The port has its own handshake, so we
    // hold the write until ready is seen at an edge.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Adds one item to the tail of the pending queue.
    task automatic queue_item(input func_t f, input int x0, input int y0,
                              input int x1, input int y1);
        flush_item_t it;
        it.func = f;
        it.min_x = COORD_W'(x0);
        it.min_y = COORD_W'(y0);
        it.max_x = COORD_W'(x1);
        it.max_y = COORD_W'(y1);
        pending_items.push_back(it);
        items_queued++;
    endtask

    // Row items ignore their coordinates, so they carry random content.
    task automatic queue_row();
        queue_item(FUNC_ROW, $urandom_range(0, 16383), $urandom_range(0, 16383),
                   $urandom_range(0, 16383), $urandom_range(0, 16383));
    endtask

    // Waits until every item has been taken and every descriptor has come
    // back, then lets the pipeline settle, since a start leaves no result
    // behind to wait for.
    task automatic drain();
        while (items_accepted != items_queued || expected_descs.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    // A well-formed rectangle inside the current screen, followed by its
    // rows. Sometimes the edges stick out past the screen, sometimes an
    // extra row is sent after the last one, and sometimes the rectangle is
    // cut short so the next start replaces it.
    task automatic queue_rect(output int sent);
        int w;
        int h;
        int x0;
        int y0;
        int x1;
        int y1;
        int nrows;
        int lo_x;
        int hi_x;
        int lo_y;
        int nsend;
        w = (int'(mdl_width) > int'(DIM_LIMIT)) ? int'(DIM_LIMIT) : int'(mdl_width);
        h = (int'(mdl_height) > int'(DIM_LIMIT)) ? int'(DIM_LIMIT) : int'(mdl_height);
        if (w < 1) w = 1;
        if (h < 1) h = 1;
        x0 = $urandom_range(0, w - 1);
        if ($urandom_range(0, 7) == 0)
            x1 = x0 + $urandom_range(1, w - x0);
        else
            x1 = x0 + $urandom_range(1, (w - x0 < 64) ? w - x0 : 64);
        y0 = $urandom_range(0, h - 1);
        nrows = $urandom_range(1, (h - y0 < 6) ? h - y0 : 6);
        y1 = y0 + nrows;
        lo_x = (x0 == 0 && $urandom_range(0, 5) == 0) ? -$urandom_range(1, 8192) : x0;
        hi_x = (x1 == w && $urandom_range(0, 5) == 0) ? x1 + $urandom_range(0, 8191 - x1) : x1;
        lo_y = (y0 == 0 && $urandom_range(0, 5) == 0) ? -$urandom_range(1, 8192) : y0;
        queue_item(FUNC_START, lo_x, lo_y, hi_x, y1);
        case ($urandom_range(0, 7))
            0:       nsend = nrows + 1;
            1:       nsend = $urandom_range(0, nrows - 1);
            default: nsend = nrows;
        endcase
        repeat (nsend) queue_row();
        sent = nsend + 1;
    endtask

    // Picks a new register setting for a random phase; the first phase
    // writes every register, later ones a random subset.
    task automatic random_config(input bit all_regs);
        if (all_regs || $urandom_range(0, 1) == 0)
            write_reg(REG_FLUSH_ENABLE, 32'($urandom_range(0, 9) != 0));
        if (all_regs || $urandom_range(0, 1) == 0)
            case ($urandom_range(0, 3))
                0:       write_reg(REG_SCREEN_WIDTH, 1);
                1:       write_reg(REG_SCREEN_WIDTH, DIM_LIMIT);
                2:       write_reg(REG_SCREEN_WIDTH, 8191);
                default: write_reg(REG_SCREEN_WIDTH, $urandom_range(1, 8191));
            endcase
        if (all_regs || $urandom_range(0, 1) == 0)
            case ($urandom_range(0, 3))
                0:       write_reg(REG_SCREEN_HEIGHT, 1);
                1:       write_reg(REG_SCREEN_HEIGHT, DIM_LIMIT);
                2:       write_reg(REG_SCREEN_HEIGHT, 8191);
                default: write_reg(REG_SCREEN_HEIGHT, $urandom_range(1, 8191));
            endcase
        if (all_regs || $urandom_range(0, 1) == 0)
            case ($urandom_range(0, 6))
                0:       write_reg(REG_LINE_STRIDE, $urandom_range(0, 1));
                1:       write_reg(REG_LINE_STRIDE, 32767);
                2:       write_reg(REG_LINE_STRIDE, 16384);
                3:       write_reg(REG_LINE_STRIDE, $urandom_range(1, 64));
                default: write_reg(REG_LINE_STRIDE, $urandom_range(0, 32767));
            endcase
        if (all_regs || $urandom_range(0, 1) == 0) begin
            if ($urandom_range(0, 4) == 0)
                write_reg(REG_APERTURE_SHIFT, $urandom_range(0, 31));
            else
                write_reg(REG_APERTURE_SHIFT,
                          $urandom_range(32'(SHIFT_MIN), 32'(SHIFT_MAX)));
        end
        // Indexes past the register list should be ignored by the block.
        if ($urandom_range(0, 9) == 0)
            write_reg(CFG_IDX_W'($urandom_range(5, 7)), $urandom_range(0, 32767));
    endtask

    // Main sequence: reset, a directed part over a few register settings,
    // then random phases. Registers only change once the block is drained.
    initial
    begin
        int phase;
        int phase_items;
        int sent;
        int pick;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: 640 x 480, stride 640, 64 KiB banks. A row with
        // nothing armed is ignored. A start covering the whole coordinate
        // range is clipped to the screen and then replaced by a small one
        // while it is still running; the spare row after it is ignored.
        gap_odds = 3;
        stall_odds = 3;
        queue_row();
        queue_item(FUNC_START, -8192, -8192, 8191, 8191);
        queue_row();
        queue_item(FUNC_START, 0, 0, 3, 2);
        repeat (3) queue_row();
        // Rows near the end of the first bank: the second row steps the
        // bank even though it fits whole.
        queue_item(FUNC_START, 600, 100, 8191, 102);
        repeat (2) queue_row();
        // An empty rectangle arms nothing.
        queue_item(FUNC_START, 5, 5, 5, 9);
        queue_row();
        drain();

        // Flushing disabled, screen above the clip limit, widest stride and
        // a shift past the top of its range.
        write_reg(REG_FLUSH_ENABLE, 0);
        write_reg(REG_SCREEN_WIDTH, 8191);
        write_reg(REG_SCREEN_HEIGHT, 8191);
        write_reg(REG_LINE_STRIDE, 32767);
        write_reg(REG_APERTURE_SHIFT, 31);
        queue_item(FUNC_START, 0, 0, 1, 1);
        queue_row();
        drain();

        // Enabled again: a start at the bottom right corner, where the
        // shadow offsets wrap around. Only half of its rows are sent here.
        write_reg(REG_FLUSH_ENABLE, 1);
        queue_item(FUNC_START, 4000, 4090, 8191, 8191);
        repeat (3) queue_row();
        drain();

        // Disabling mid-flush lets the running rectangle finish. The stride
        // now exceeds the bank size, and the shift below its range clamps.
        write_reg(REG_FLUSH_ENABLE, 0);
        write_reg(REG_APERTURE_SHIFT, 0);
        write_reg(REG_LINE_STRIDE, 16384);
        repeat (4) queue_row();
        drain();

        // A stride shorter than the row: the rows overlap.
        write_reg(REG_FLUSH_ENABLE, 1);
        write_reg(REG_APERTURE_SHIFT, 32'(SHIFT_MIN));
        write_reg(REG_LINE_STRIDE, 16);
        queue_item(FUNC_START, 0, 0, 1000, 3);
        repeat (3) queue_row();
        drain();

        // Random phases. The sender pauses at the end of each one until all
        // descriptors are back. The last few phases run with no idling.
        for (phase = 0; phase < 20; phase++) begin
            random_config(phase == 0);
            // The long hold needs descriptors to back up, so flushing is on.
            if (phase == 4)
                write_reg(REG_FLUSH_ENABLE, 1);
            if (phase >= 17) begin
                gap_odds = 0;
                stall_odds = 0;
            end
            else begin
                case ($urandom_range(0, 3))
                    0:       gap_odds = 0;
                    1:       gap_odds = 2;
                    2:       gap_odds = 5;
                    default: gap_odds = 12;
                endcase
                case ($urandom_range(0, 3))
                    0:       stall_odds = 0;
                    1:       stall_odds = 2;
                    2:       stall_odds = 5;
                    default: stall_odds = 12;
                endcase
            end
            phase_items = 0;
            while (phase_items < 36) begin
                pick = $urandom_range(0, 19);
                if (pick < 17) begin
                    queue_rect(sent);
                    phase_items += sent;
                end
                else if (pick < 19) begin
                    queue_item(FUNC_START, $urandom_range(0, 16383), $urandom_range(0, 16383),
                               $urandom_range(0, 16383), $urandom_range(0, 16383));
                    phase_items++;
                end
                else begin
                    queue_row();
                end
            end
            // Once, the receiver stops taking descriptors for a long time
            // while this phase's items are still being offered.
            if (phase == 4)
                long_hold_go = 1'b1;
            drain();
        end

        if (error_count == 0)
            $display("** banked_framebuffer_flush_addresser_unit: PASSED **");
        else
            $display("** banked_framebuffer_flush_addresser_unit: FAILED **");
        $finish;
    end

    // Watchdog: far beyond the slowest legal run of this sequence.
    initial
    begin
        #5_000_000;
        $display("** banked_framebuffer_flush_addresser_unit: FAILED **");
        $finish;
    end

endmodule
